### hw/rtl/m4mul_pkg.sv
// Shared types and constants for the 4x4 fixed-point matrix multiplier.
package m4mul_pkg;

    // Matrix geometry; row and column ports are 2 bits wide
    localparam int MATRIX_SIZE = 4;
    localparam int IDX_W       = $clog2(MATRIX_SIZE);

    // Request mode codes
    localparam logic [1:0] MODE_WR_LEFT  = 2'd0;
    localparam logic [1:0] MODE_WR_RIGHT = 2'd1;
    localparam logic [1:0] MODE_MULTIPLY = 2'd2;

    // Q16.16 constants
    localparam logic signed [31:0] ONE_Q16  = 32'sh0001_0000;
    localparam logic signed [31:0] ZERO_Q16 = 32'sh0000_0000;
    localparam logic signed [31:0] SAT_MAX  = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] SAT_MIN  = 32'sh8000_0000;
    localparam int                 FRAC_W   = 16;

    // Controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ISSUE,
        ST_DRAIN
    } m4mul_state_t;

    // Commands from controller to datapath
    typedef struct packed {
        logic wr_left;    // store element_value into left matrix
        logic wr_right;   // store element_value into right matrix
        logic issue;      // read one operand pair this cycle
        logic first;      // first term of a dot product
        logic last_term;  // final term of a dot product
        logic last_elem;  // current element is the final one of the product
    } m4mul_cmd_t;

endpackage

### hw/rtl/m4mul_ctrl.sv
// Controller FSM: sequences element writes and the row/column/term walk of a product.
module m4mul_ctrl
    import m4mul_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  logic [1:0]       mode,
    output logic             in_stall,
    input  logic             result_loaded,
    output m4mul_cmd_t       cmd,
    output logic [IDX_W-1:0] cur_row,
    output logic [IDX_W-1:0] cur_col,
    output logic [IDX_W-1:0] cur_term
);

    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(MATRIX_SIZE - 1);

    m4mul_state_t     state_reg, state_next;
    logic [IDX_W-1:0] row_reg, row_next;
    logic [IDX_W-1:0] col_reg, col_next;
    logic [IDX_W-1:0] term_reg, term_next;
    logic             accept;
    logic             term_done;
    logic             elem_last;

    assign accept    = in_valid && (state_reg == ST_IDLE);
    assign term_done = (term_reg == IDX_LAST);
    assign elem_last = (row_reg == IDX_LAST) && (col_reg == IDX_LAST);

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && (mode == MODE_MULTIPLY))
                    state_next = ST_ISSUE;
            end
            ST_ISSUE:
            begin
                if (term_done)
                    state_next = ST_DRAIN;
            end
            ST_DRAIN:
            begin
                if (result_loaded)
                    state_next = elem_last ? ST_IDLE : ST_ISSUE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    // Outputs
    always_comb
    begin
        cmd           = '0;
        in_stall      = (state_reg != ST_IDLE);
        cmd.wr_left   = accept && (mode == MODE_WR_LEFT);
        cmd.wr_right  = accept && (mode == MODE_WR_RIGHT);
        cmd.issue     = (state_reg == ST_ISSUE);
        cmd.first     = (term_reg == '0);
        cmd.last_term = term_done;
        cmd.last_elem = elem_last;
    end

    // Row / column / term counters
    always_comb
    begin
        row_next  = row_reg;
        col_next  = col_reg;
        term_next = term_reg;
        if (accept && (mode == MODE_MULTIPLY))
        begin
            row_next  = '0;
            col_next  = '0;
            term_next = '0;
        end
        else if (state_reg == ST_ISSUE)
        begin
            term_next = term_done ? '0 : term_reg + 1'b1;
        end
        else if ((state_reg == ST_DRAIN) && result_loaded && !elem_last)
        begin
            if (col_reg == IDX_LAST)
            begin
                col_next = '0;
                row_next = row_reg + 1'b1;
            end
            else
            begin
                col_next = col_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            row_reg   <= '0;
            col_reg   <= '0;
            term_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            row_reg   <= row_next;
            col_reg   <= col_next;
            term_reg  <= term_next;
        end
    end

    assign cur_row  = row_reg;
    assign cur_col  = col_reg;
    assign cur_term = term_reg;

endmodule

### hw/rtl/m4mul_datapath.sv
// Datapath: matrix stores, operand read, multiply, accumulate, saturate and output register.
module m4mul_datapath
    import m4mul_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  m4mul_cmd_t         cmd,
    input  logic [IDX_W-1:0]   cur_row,
    input  logic [IDX_W-1:0]   cur_col,
    input  logic [IDX_W-1:0]   cur_term,
    input  logic [1:0]         row_index,
    input  logic [1:0]         column_index,
    input  logic signed [31:0] element_value,
    output logic               result_loaded,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [1:0]         out_row,
    output logic [1:0]         out_column,
    output logic signed [31:0] product_value,
    output logic               saturated,
    output logic               last
);

    localparam int CELLS  = MATRIX_SIZE * MATRIX_SIZE;
    localparam int CELL_W = $clog2(CELLS);
    localparam int ACC_W  = 64 + $clog2(MATRIX_SIZE);
    localparam int HI_LSB = 31 + FRAC_W;

    // Element stores; entries never written read as identity
    logic signed [31:0] left_mem  [CELLS];
    logic signed [31:0] right_mem [CELLS];
    logic [CELLS-1:0]   left_vld_reg;
    logic [CELLS-1:0]   right_vld_reg;

    logic               idx_ok;
    logic [CELL_W-1:0]  wr_addr;
    logic [CELL_W-1:0]  left_rd_addr;
    logic [CELL_W-1:0]  right_rd_addr;

    // Read stage
    logic signed [31:0] left_rd_reg, right_rd_reg;
    logic               left_rdv_reg, right_rdv_reg;
    logic               left_diag_reg, right_diag_reg;
    logic               s1_vld_reg, s1_first_reg, s1_last_reg;
    logic signed [31:0] op_a, op_b;

    // Multiply stage
    logic signed [63:0] prod_reg;
    logic               s2_vld_reg, s2_first_reg, s2_last_reg;

    // Accumulate stage
    logic signed [ACC_W-1:0] acc_reg, acc_next;
    logic                    done_reg, done_next;

    // Output stage
    logic                      out_valid_reg, out_valid_next;
    logic [1:0]                out_row_reg, out_col_reg;
    logic signed [31:0]        out_value_reg;
    logic                      out_sat_reg, out_last_reg;
    logic                      out_free;
    logic [ACC_W-HI_LSB-1:0]   acc_hi;
    logic                      fits;
    logic signed [31:0]        sat_value;

    // Write and read addresses
    assign idx_ok        = (row_index < MATRIX_SIZE) && (column_index < MATRIX_SIZE);
    assign wr_addr       = CELL_W'(row_index * MATRIX_SIZE + column_index);
    assign left_rd_addr  = CELL_W'(cur_row * MATRIX_SIZE + cur_term);
    assign right_rd_addr = CELL_W'(cur_term * MATRIX_SIZE + cur_col);

    // Store writes and registered reads
    always_ff @(posedge clk)
    begin
        if (cmd.wr_left && idx_ok)
            left_mem[wr_addr] <= element_value;
        if (cmd.wr_right && idx_ok)
            right_mem[wr_addr] <= element_value;
        if (cmd.issue)
        begin
            left_rd_reg    <= left_mem[left_rd_addr];
            right_rd_reg   <= right_mem[right_rd_addr];
            left_rdv_reg   <= left_vld_reg[left_rd_addr];
            right_rdv_reg  <= right_vld_reg[right_rd_addr];
            left_diag_reg  <= (cur_row == cur_term);
            right_diag_reg <= (cur_term == cur_col);
        end
    end

    // Written-entry flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_vld_reg  <= '0;
            right_vld_reg <= '0;
        end
        else
        begin
            if (cmd.wr_left && idx_ok)
                left_vld_reg[wr_addr] <= 1'b1;
            if (cmd.wr_right && idx_ok)
                right_vld_reg[wr_addr] <= 1'b1;
        end
    end

    // Operand select: unwritten entries hold identity
    assign op_a = left_rdv_reg  ? left_rd_reg  : (left_diag_reg  ? ONE_Q16 : ZERO_Q16);
    assign op_b = right_rdv_reg ? right_rd_reg : (right_diag_reg ? ONE_Q16 : ZERO_Q16);

    // Multiply
    always_ff @(posedge clk)
    begin
        prod_reg <= op_a * op_b;
    end

    // Accumulate; done flags the held sum until the output register takes it
    assign out_free      = !out_valid_reg || !out_stall;
    assign result_loaded = done_reg && out_free;

    always_comb
    begin
        acc_next  = acc_reg;
        done_next = done_reg && !result_loaded;
        if (s2_vld_reg)
        begin
            if (s2_first_reg)
                acc_next = ACC_W'(prod_reg);
            else
                acc_next = acc_reg + ACC_W'(prod_reg);
            if (s2_last_reg)
                done_next = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
    end

    // Floor shift by the fraction width, then saturate
    assign acc_hi    = acc_reg[ACC_W-1:HI_LSB];
    assign fits      = (acc_hi == '0) || (acc_hi == '1);
    assign sat_value = fits ? acc_reg[HI_LSB:FRAC_W]
                            : (acc_reg[ACC_W-1] ? SAT_MIN : SAT_MAX);

    assign out_valid_next = result_loaded || (out_valid_reg && out_stall);

    always_ff @(posedge clk)
    begin
        if (result_loaded)
        begin
            out_row_reg   <= 2'(cur_row);
            out_col_reg   <= 2'(cur_col);
            out_value_reg <= sat_value;
            out_sat_reg   <= !fits;
            out_last_reg  <= cmd.last_elem;
        end
    end

    // Pipeline control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg    <= 1'b0;
            s1_first_reg  <= 1'b0;
            s1_last_reg   <= 1'b0;
            s2_vld_reg    <= 1'b0;
            s2_first_reg  <= 1'b0;
            s2_last_reg   <= 1'b0;
            done_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_vld_reg    <= cmd.issue;
            s1_first_reg  <= cmd.first;
            s1_last_reg   <= cmd.last_term;
            s2_vld_reg    <= s1_vld_reg;
            s2_first_reg  <= s1_first_reg;
            s2_last_reg   <= s1_last_reg;
            done_reg      <= done_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign out_row       = out_row_reg;
    assign out_column    = out_col_reg;
    assign product_value = out_value_reg;
    assign saturated     = out_sat_reg;
    assign last          = out_last_reg;

endmodule

### hw/rtl/matrix4_multiply_top.sv
// A write request is stored when it is accepted; each product element passes the read, multiply,
// accumulate and output registers after its terms are issued.
// Products: one element at a time, set by the single multiply-accumulate unit reading one
// operand pair a cycle while issuing; the next element is issued only once the last is loaded.
// Reset: both matrices read as identity through per-entry written flags, no clearing pass.
// Top level of the Q16.16 matrix multiplier.
module matrix4_multiply_top
    import m4mul_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [1:0]         mode,
    input  logic [1:0]         row_index,
    input  logic [1:0]         column_index,
    input  logic signed [31:0] element_value,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [1:0]         out_row,
    output logic [1:0]         out_column,
    output logic signed [31:0] product_value,
    output logic               saturated,
    output logic               last
);

    m4mul_cmd_t       cmd;
    logic             result_loaded;
    logic [IDX_W-1:0] cur_row;
    logic [IDX_W-1:0] cur_col;
    logic [IDX_W-1:0] cur_term;

    m4mul_ctrl u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .mode          (mode),
        .in_stall      (in_stall),
        .result_loaded (result_loaded),
        .cmd           (cmd),
        .cur_row       (cur_row),
        .cur_col       (cur_col),
        .cur_term      (cur_term)
    );

    m4mul_datapath u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .cur_row       (cur_row),
        .cur_col       (cur_col),
        .cur_term      (cur_term),
        .row_index     (row_index),
        .column_index  (column_index),
        .element_value (element_value),
        .result_loaded (result_loaded),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .out_row       (out_row),
        .out_column    (out_column),
        .product_value (product_value),
        .saturated     (saturated),
        .last          (last)
    );

endmodule

### hw/rtl/m4mul_checker.sv
// Port-level checker for the matrix multiplier, bound to the top level.
module m4mul_checker
    import m4mul_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_stall,
    input logic [1:0]         mode,
    input logic               out_valid,
    input logic               out_stall,
    input logic [1:0]         out_row,
    input logic [1:0]         out_column,
    input logic signed [31:0] product_value,
    input logic               saturated,
    input logic               last
);

    localparam logic [1:0] LAST_IDX = 2'(MATRIX_SIZE - 1);

    // A stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(product_value) && $stable(last))
    else $error("stalled result changed");

    // An accepted multiply request blocks further requests
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && (mode == MODE_MULTIPLY) |=> in_stall)
    else $error("multiply request did not make the block busy");

    // Mid-product elements only appear while the block is busy
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !last |-> in_stall)
    else $error("non-final element shown while idle");

    // Final element sits at the bottom-right corner
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && last |-> (out_row == LAST_IDX) && (out_column == LAST_IDX))
    else $error("final element at wrong position");

    // A clipped element carries a range limit
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && saturated |-> (product_value == SAT_MAX) || (product_value == SAT_MIN))
    else $error("saturated element is not a range limit");

endmodule

bind matrix4_multiply_top m4mul_checker u_m4mul_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .mode          (mode),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_row       (out_row),
    .out_column    (out_column),
    .product_value (product_value),
    .saturated     (saturated),
    .last          (last)
);
